>>> rtl/core/fscd_pkg.sv
package fscd_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_DELAY_DEPTH = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Register and field widths.
    localparam int LVL_W     = 15;
    localparam int LEN_W     = 11;
    localparam int MODE_W    = 2;
    localparam int GAIN_W    = 15;
    localparam int OUT_W     = 31;
    localparam int OUT_TW    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    // Inside the soft region the magnitude is below the clip level.
    localparam int MAG_W  = LVL_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int CUBE_W = 3 * MAG_W;
    localparam int DIV_W  = SQ_W + 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN   = 2'd3;

    // Rectifier modes; the unused code behaves like no rectification.
    localparam logic [MODE_W-1:0] RECT_NONE = 2'd0;
    localparam logic [MODE_W-1:0] RECT_ABS  = 2'd1;
    localparam logic [MODE_W-1:0] RECT_NEG  = 2'd2;

    // Register values after reset.
    localparam logic [LVL_W-1:0]  RST_CLIP_LEVEL = 15'd20000;
    localparam logic [LEN_W-1:0]  RST_DELAY_LEN  = 11'd1;
    localparam logic [GAIN_W-1:0] RST_OUT_GAIN   = 15'd1;

    // Settings used by the arithmetic unit.
    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [GAIN_W-1:0] gain;
    } t_calc_cfg;

    // Ring entries hold raw samples and clipped sums; they are at least 16 bits wide.
    function automatic int ring_width(input int sample_bits);
        return (sample_bits > 16) ? sample_bits : 16;
    endfunction

endpackage

>>> rtl/core/feedback_soft_clip_distortion.sv
// Feedback soft-clip distortion.
// Input channel s_axis carries one signed sample per request; output channel
// m_axis carries one distorted sample, multiplied by the output gain, per
// input sample. Registers must be written by the user through i_cfg_we /
// i_cfg_idx / i_cfg_data only while the block is idle; the block does not
// enforce this: 0 clip level, 1 delay length, 2 rectify mode, 3 output gain.
// One sample is processed at a time. A sample first passes the delay ring
// (while the ring fills, a direct write; once feedback is active, a memory
// read, then clip and write back), then a bit-serial unit that works out
// the square, the cube, the divide by 3*L^2, the rounded correction and the
// gain multiply in that order, then hands the result over. A sample that
// hard clips skips to the gain multiply. The next sample is accepted only
// once its result has gone to the output register, so the serial unit sets
// the throughput.
// The result sits in an output register, so the next sample is accepted as
// soon as the unit is free even if the receiver stalls; a finished result
// that finds the output register still full waits in the unit.
// Synchronous reset clears the fill count, the ring pointer, the handshakes
// and restores the register defaults; ring contents are left as they are.
module feedback_soft_clip_distortion import fscd_pkg::*; #(
    parameter int DELAY_DEPTH = DEF_DELAY_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int IN_TW = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int T_W   = ring_width(SAMPLE_BITS) + 1,
    localparam int CNT_W = $clog2(DELAY_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_TW-1:0]     s_axis_tdata,   // sample_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_TW-1:0]    m_axis_tdata,   // sample_out
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RING = 3'b010,
        T_CALC = 3'b100
    } t_top_state;

    t_top_state         r_state, n_state;
    logic [LVL_W-1:0]   r_clip;
    logic [LEN_W-1:0]   r_len;
    logic [MODE_W-1:0]  r_mode;
    logic [GAIN_W-1:0]  r_gain;
    logic               r_oval, n_oval;
    logic [OUT_W-1:0]   r_odata;

    logic [CNT_W-1:0]   len_eff;
    logic               in_acc;
    logic               ring_valid;
    logic signed [T_W-1:0] ring_t;
    logic               calc_done;
    logic [OUT_W-1:0]   calc_result;
    logic               load_out;
    t_calc_cfg          calc_cfg;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= RST_CLIP_LEVEL;
            r_len  <= RST_DELAY_LEN;
            r_mode <= RECT_NONE;
            r_gain <= RST_OUT_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLIP_LEVEL: r_clip <= i_cfg_data[LVL_W-1:0];
                CFG_DELAY_LEN:  r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_RECT_MODE:  r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_OUT_GAIN:   r_gain <= i_cfg_data[GAIN_W-1:0];
            endcase
        end
    end

    // Effective delay length: zero acts as one, capped at the ring depth.
    always_comb begin
        if (r_len == '0) begin
            len_eff = CNT_W'(1);
        end else if (32'(r_len) > 32'(DELAY_DEPTH)) begin
            len_eff = CNT_W'(DELAY_DEPTH);
        end else begin
            len_eff = CNT_W'(r_len);
        end
    end

    assign calc_cfg = '{level: r_clip, gain: r_gain};

    // Sequencing of one sample through ring and arithmetic unit.
    always_comb begin
        in_acc   = s_axis_tvalid && s_axis_tready;
        load_out = (r_state == T_CALC) && calc_done && (!r_oval || m_axis_tready);
        n_state  = r_state;
        unique case (r_state)
            T_IDLE: if (in_acc) n_state = T_RING;
            T_RING: if (ring_valid) n_state = T_CALC;
            T_CALC: if (load_out) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
        n_oval = r_oval;
        if (load_out) begin
            n_oval = 1'b1;
        end else if (m_axis_tready) begin
            n_oval = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_odata <= calc_result;
        end
    end

    fscd_ring #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc),
        .i_sample (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_level  (r_clip),
        .i_len    (len_eff),
        .i_mode   (r_mode),
        .o_valid  (ring_valid),
        .o_t      (ring_t)
    );

    fscd_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ring_valid),
        .i_t      (ring_t),
        .i_cfg    (calc_cfg),
        .i_take   (load_out),
        .o_done   (calc_done),
        .o_result (calc_result)
    );

    assign s_axis_tready = (r_state == T_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {{(OUT_TW - OUT_W){1'b0}}, r_odata};

endmodule

>>> rtl/core/fscd_ring.sv
module fscd_ring import fscd_pkg::*; #(
    parameter int DELAY_DEPTH = DEF_DELAY_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int RING_W = ring_width(SAMPLE_BITS),
    localparam int T_W    = RING_W + 1,
    localparam int CNT_W  = $clog2(DELAY_DEPTH + 1),
    localparam int AW     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic        [LVL_W-1:0]       i_level,
    input  logic        [CNT_W-1:0]       i_len,
    input  logic        [MODE_W-1:0]      i_mode,
    output logic                          o_valid,
    output logic signed [T_W-1:0]         o_t
);

    logic signed [RING_W-1:0]      r_mem [DELAY_DEPTH];
    logic signed [RING_W-1:0]      r_rd;
    logic        [CNT_W-1:0]       r_fill, n_fill;
    logic        [CNT_W-1:0]       r_ptr, n_ptr;
    logic                          r_wait, n_wait;
    logic                          r_valid, n_valid;
    logic        [AW-1:0]          r_wb_addr, n_wb_addr;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic signed [T_W-1:0]         r_t, n_t;

    logic                          mem_we;
    logic        [AW-1:0]          mem_waddr;
    logic        [AW-1:0]          rd_addr;
    logic signed [RING_W-1:0]      mem_wdata;
    logic        [CNT_W-1:0]       ptr_use;
    logic signed [T_W-1:0]         lvl_s;
    logic signed [T_W-1:0]         sum;
    logic signed [T_W-1:0]         clipped;
    logic signed [T_W-1:0]         rect_in;
    logic signed [T_W-1:0]         rect_out;

    // Feedback sum clipped to the symmetric level.
    always_comb begin
        ptr_use = (r_ptr >= i_len) ? '0 : r_ptr;
        lvl_s   = signed'(T_W'(i_level));
        sum     = T_W'(r_smp) + T_W'(r_rd);
        if (sum >= lvl_s) begin
            clipped = lvl_s;
        end else if (sum <= -lvl_s) begin
            clipped = -lvl_s;
        end else begin
            clipped = sum;
        end
    end

    // Optional rectifier on the value that leaves the ring stage.
    always_comb begin
        rect_in  = r_wait ? clipped : T_W'(i_sample);
        rect_out = rect_in;
        if (i_mode == RECT_ABS && rect_in < 0) begin
            rect_out = -rect_in;
        end else if (i_mode == RECT_NEG && rect_in > 0) begin
            rect_out = -rect_in;
        end
    end

    // Fill the ring first, then read, clip and write back at the pointer.
    always_comb begin
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_wait    = 1'b0;
        n_valid   = 1'b0;
        n_t       = r_t;
        n_wb_addr = r_wb_addr;
        mem_we    = 1'b0;
        mem_waddr = r_wb_addr;
        mem_wdata = clipped[RING_W-1:0];
        rd_addr   = ptr_use[AW-1:0];
        if (r_wait) begin
            mem_we  = 1'b1;
            n_valid = 1'b1;
            n_t     = rect_out;
        end else if (i_start) begin
            if (r_fill < i_len) begin
                mem_we    = 1'b1;
                mem_waddr = r_fill[AW-1:0];
                mem_wdata = RING_W'(i_sample);
                n_fill    = r_fill + CNT_W'(1);
                n_valid   = 1'b1;
                n_t       = rect_out;
            end else begin
                n_wait    = 1'b1;
                n_wb_addr = ptr_use[AW-1:0];
                n_ptr     = ptr_use + CNT_W'(1);
            end
        end
    end

    // Delay memory with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_ptr   <= '0;
            r_wait  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_ptr   <= n_ptr;
            r_wait  <= n_wait;
            r_valid <= n_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_t       <= n_t;
        r_wb_addr <= n_wb_addr;
        if (i_start) begin
            r_smp <= i_sample;
        end
    end

    assign o_valid = r_valid;
    assign o_t     = r_t;

endmodule

>>> rtl/core/fscd_calc.sv
module fscd_calc import fscd_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int T_W = ring_width(SAMPLE_BITS) + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [T_W-1:0] i_t,
    input  t_calc_cfg             i_cfg,
    input  logic                  i_take,
    output logic                  o_done,
    output logic [OUT_W-1:0]      o_result
);

    localparam int STEP_W = $clog2(MAG_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_SQR  = 7'b0000010,
        C_CUBE = 7'b0000100,
        C_DIV  = 7'b0001000,
        C_FIX  = 7'b0010000,
        C_GAIN = 7'b0100000,
        C_DONE = 7'b1000000
    } t_calc_state;

    t_calc_state        r_state, n_state;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic [MAG_W-1:0]   r_a, n_a;
    logic [SQ_W-1:0]    r_pa, n_pa;
    logic [SQ_W-1:0]    r_pl, n_pl;
    logic [CUBE_W-1:0]  r_pc, n_pc;
    logic [DIV_W-1:0]   r_d, n_d;
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [SQ_W-1:0]    r_pg, n_pg;

    logic [T_W-1:0]     a_full;
    logic               last;
    logic [MAG_W:0]     sq_sum_a;
    logic [MAG_W:0]     sq_sum_l;
    logic [SQ_W:0]      cube_sum;
    logic [CUBE_W-1:0]  cube_next;
    logic [DIV_W:0]     div_shift;
    logic [DIV_W:0]     div_diff;
    logic               div_ge;
    logic [MAG_W-1:0]   corr;
    logic [MAG_W-1:0]   fix_mag;
    logic [MAG_W:0]     gain_sum;
    logic [OUT_W-1:0]   mag_out;

    // One bit per cycle: shift-add multiplies and a restoring divide.
    always_comb begin
        a_full    = i_t[T_W-1] ? T_W'(-i_t) : T_W'(i_t);
        last      = (r_cnt == LAST_STEP);
        sq_sum_a  = {1'b0, r_pa[SQ_W-1:MAG_W]} + (r_pa[0] ? {1'b0, r_a} : '0);
        sq_sum_l  = {1'b0, r_pl[SQ_W-1:MAG_W]} + (r_pl[0] ? {1'b0, i_cfg.level} : '0);
        cube_sum  = {1'b0, r_pc[CUBE_W-1:MAG_W]} + (r_pc[0] ? {1'b0, r_pa} : '0);
        cube_next = {cube_sum, r_pc[MAG_W-1:1]};
        div_shift = {r_rem, r_pc[MAG_W-1]};
        div_diff  = div_shift - {1'b0, r_d};
        div_ge    = (div_shift >= {1'b0, r_d});
        // Rounding the correction up: add one when the remainder is not zero.
        corr      = r_pc[MAG_W-1:0] + MAG_W'(r_rem != '0);
        fix_mag   = r_a - corr;
        gain_sum  = {1'b0, r_pg[SQ_W-1:MAG_W]} + (r_pg[0] ? {1'b0, i_cfg.gain} : '0);
        mag_out   = OUT_W'({1'b0, r_pg});
    end

    // Sequencer over square, cube, divide, correction and gain.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_a     = r_a;
        n_pa    = r_pa;
        n_pl    = r_pl;
        n_pc    = r_pc;
        n_d     = r_d;
        n_rem   = r_rem;
        n_pg    = r_pg;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_cnt = '0;
                    n_neg = i_t[T_W-1];
                    if (a_full >= T_W'(i_cfg.level)) begin
                        // Hard clip: the magnitude is the level itself.
                        n_pg    = {{MAG_W{1'b0}}, i_cfg.level};
                        n_state = C_GAIN;
                    end else begin
                        n_a     = a_full[MAG_W-1:0];
                        n_pa    = {{MAG_W{1'b0}}, a_full[MAG_W-1:0]};
                        n_pl    = {{MAG_W{1'b0}}, i_cfg.level};
                        n_state = C_SQR;
                    end
                end
            end
            C_SQR: begin
                n_pa  = {sq_sum_a, r_pa[MAG_W-1:1]};
                n_pl  = {sq_sum_l, r_pl[MAG_W-1:1]};
                n_cnt = r_cnt + STEP_W'(1);
                if (last) begin
                    n_cnt   = '0;
                    n_pc    = {{SQ_W{1'b0}}, r_a};
                    n_state = C_CUBE;
                end
            end
            C_CUBE: begin
                n_pc  = cube_next;
                n_d   = {2'b00, r_pl} + {1'b0, r_pl, 1'b0};
                n_cnt = r_cnt + STEP_W'(1);
                if (last) begin
                    n_cnt   = '0;
                    n_rem   = DIV_W'(cube_next[CUBE_W-1:MAG_W]);
                    n_state = C_DIV;
                end
            end
            C_DIV: begin
                n_rem              = div_ge ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
                n_pc[MAG_W-1:0]    = {r_pc[MAG_W-2:0], div_ge};
                n_cnt              = r_cnt + STEP_W'(1);
                if (last) begin
                    n_cnt   = '0;
                    n_state = C_FIX;
                end
            end
            C_FIX: begin
                n_pg    = {{MAG_W{1'b0}}, fix_mag};
                n_state = C_GAIN;
            end
            C_GAIN: begin
                n_pg  = {gain_sum, r_pg[MAG_W-1:1]};
                n_cnt = r_cnt + STEP_W'(1);
                if (last) begin
                    n_cnt   = '0;
                    n_state = C_DONE;
                end
            end
            C_DONE: begin
                if (i_take) begin
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_a   <= n_a;
        r_pa  <= n_pa;
        r_pl  <= n_pl;
        r_pc  <= n_pc;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_pg  <= n_pg;
    end

    assign o_done   = (r_state == C_DONE);
    assign o_result = r_neg ? -mag_out : mag_out;

endmodule

>>> rtl/core/fscd_chk.sv
module fscd_chk import fscd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_TW-1:0] m_axis_tdata
);

    // After reset the block is empty and ready for a sample.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Only one sample is in work at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // A new result is loaded only from a busy block.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without work in progress");

endmodule

bind feedback_soft_clip_distortion fscd_chk u_fscd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
